>>> src/bmc_pkg.sv
package bmc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } bmc_mode_t;

  // one item handed from the scan control to the window stage
  typedef struct packed {
    logic valid;
    logic pix;
    logic emit;
    logic border;
    logic row_end;
    logic frame_end;
  } bmc_item_t;

endpackage

>>> src/bmc_in_if.sv
interface bmc_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic pixel_in;

  modport source (output valid, output operation, output pixel_in, input ready);
  modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

>>> src/bmc_out_if.sv
interface bmc_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic row_end;
  logic frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input row_end, input frame_end, output ready);
endinterface

>>> src/bmc_line_mem.sv
module bmc_line_mem
  import bmc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wb_en,
  input  logic                         wb_pix,
  output logic                         above,
  output logic                         middle
);

  localparam int CW = $clog2(MAX_WIDTH);

  // entry bit 1 is the row above, bit 0 the middle row
  logic [1:0]    mem [MAX_WIDTH];
  logic [1:0]    rd_q_r;
  logic [CW-1:0] addr_r;
  logic          last_valid_r;
  logic [CW-1:0] last_addr_r;
  logic [1:0]    last_data_r;
  logic [1:0]    q;
  logic          hit;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
      addr_r <= rd_addr;
    end
    if (wb_en) begin
      mem[addr_r] <= {middle, wb_pix};
      last_addr_r <= addr_r;
      last_data_r <= {middle, wb_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_valid_r <= 1'b0;
    end else if (wb_en) begin
      last_valid_r <= 1'b1;
    end
  end

  // a read in the same cycle as a write to that column is forwarded the new data
  assign hit    = last_valid_r && (last_addr_r == addr_r);
  assign q      = hit ? last_data_r : rd_q_r;
  assign above  = q[1];
  assign middle = q[0];

endmodule

>>> src/bmc_scan_ctrl.sv
module bmc_scan_ctrl
  import bmc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         accept,
  input  logic                         operation,
  input  logic                         pixel_in,
  output bmc_item_t                    item,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output bmc_mode_t                    mode,
  output logic                         restart
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int HB = $clog2(MAX_HEIGHT + 1);
  localparam int RB = $clog2(MAX_HEIGHT + 2);

  bmc_mode_t             mode_r;
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic [CW-1:0]         in_col_r, in_col_nxt;
  logic [RB-1:0]         in_row_r, in_row_nxt;
  logic [CW-1:0]         out_col_r, out_col_nxt;
  logic [HB-1:0]         out_row_r, out_row_nxt;
  logic [WB-1:0]         w_eff;
  logic [HB-1:0]         h_eff;
  logic                  pixels_done;
  logic                  take;
  logic                  col_last;
  logic                  oc_last;
  logic                  or_last;
  logic                  emit;

  // size registers clamp into 1..max
  always_comb begin
    if (width_r == '0) begin
      w_eff = WB'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HB'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HB'(MAX_HEIGHT);
    end else begin
      h_eff = HB'(height_r);
    end
  end

  assign pixels_done = in_row_r >= RB'(h_eff);
  // a drain before the last pixel is swallowed
  assign take        = accept && !(operation == OP_DRAIN && !pixels_done);
  assign col_last    = (WB'(in_col_r) + WB'(1)) >= w_eff;
  // results start one row plus one pixel into the frame
  assign emit        = (in_row_r >= RB'(2)) || (in_row_r == RB'(1) && in_col_r != '0);
  assign oc_last     = (WB'(out_col_r) + WB'(1)) >= w_eff;
  assign or_last     = (out_row_r + HB'(1)) >= h_eff;

  assign restart = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);
  assign col     = in_col_r;
  assign mode    = mode_r;

  always_comb begin
    item.valid     = take;
    item.pix       = pixels_done ? 1'b0 : pixel_in;
    item.emit      = emit;
    item.border    = (out_row_r == '0) || (out_col_r == '0) || or_last || oc_last;
    item.row_end   = oc_last;
    item.frame_end = oc_last && or_last;
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (take) begin
      if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RB'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (emit) begin
        if (oc_last && or_last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (oc_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HB'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ERODE;
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:   mode_r   <= bmc_mode_t'(cfg_data[0]);
          CFG_WIDTH:  width_r  <= cfg_data;
          CFG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

>>> src/bmc_window.sv
module bmc_window
  import bmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bmc_item_t item,
  input  bmc_mode_t mode,
  input  logic      restart,
  input  logic      above,
  input  logic      middle,
  input  logic      out_ready,
  output logic      hold,
  output logic      wb_en,
  output logic      wb_pix,
  output logic      out_valid,
  output logic      out_pixel,
  output logic      out_row_end,
  output logic      out_frame_end
);

  localparam logic [8:0] SHIFT_MASK = 9'h0DB;

  bmc_item_t  s1_r;
  logic [8:0] window_r, window_nxt;
  logic [8:0] win_shift;
  logic       out_valid_r;
  logic       out_pixel_r;
  logic       out_row_end_r;
  logic       out_frame_end_r;
  logic       can_move;
  logic       advance;
  logic       res;

  assign can_move = !out_valid_r || out_ready;
  assign hold     = s1_r.valid && !can_move;
  assign advance  = s1_r.valid && can_move;
  assign wb_en    = advance;
  assign wb_pix   = s1_r.pix;

  // bit = row*3 + column, column 0 oldest, row 0 uppermost
  assign win_shift = ((window_r >> 1) & SHIFT_MASK)
                   | {s1_r.pix, 2'b00, middle, 2'b00, above, 2'b00};

  always_comb begin
    if (s1_r.border) begin
      res = win_shift[4];
    end else if (mode == MODE_ERODE) begin
      res = win_shift[4] & win_shift[1] & win_shift[7] & win_shift[3] & win_shift[5];
    end else begin
      res = win_shift[4] | win_shift[1] | win_shift[7] | win_shift[3] | win_shift[5];
    end
  end

  always_comb begin
    window_nxt = window_r;
    if (restart) begin
      window_nxt = '0;
    end else if (advance) begin
      window_nxt = (s1_r.emit && s1_r.frame_end) ? 9'd0 : win_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      window_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!hold) begin
        s1_r <= item;
      end
      window_r <= window_nxt;
      if (advance && s1_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_r.emit) begin
      out_pixel_r     <= res;
      out_row_end_r   <= s1_r.row_end;
      out_frame_end_r <= s1_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule

>>> src/binary_morphology_cross.sv
// Streaming 3x3 cross erosion/dilation of a binary image.
// in_if carries one item per transfer: operation selects a pixel (raster
// order) or a drain tick; out_if carries pixel_out with row_end and
// frame_end marks. cfg_we/cfg_index/cfg_data write mode, width and height;
// a width or height write restarts the frame. Write only while idle.
// A frame takes width*height pixel items followed by width+1 drain ticks;
// results trail the input by one row plus one pixel in items.
// A result passes the window stage register, then the output register.
// Throughput is one item per cycle unless out_if stalls: each column of the
// line memory is read at transfer and written back through a second port,
// with a forwarding register for back to back accesses to one column.
// Reset sets erosion and a 1024x1024 frame and clears the counters; the line
// memory holds no reset value and needs no clearing pass.
// When out_if stalls, one item still enters behind the held result, then
// in_if.ready drops until the result is taken.
module binary_morphology_cross
  import bmc_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bmc_in_if.sink                in_if,
  bmc_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  bmc_item_t     item;
  bmc_mode_t     mode;
  logic [CW-1:0] col;
  logic          restart;
  logic          accept;
  logic          hold;
  logic          wb_en;
  logic          wb_pix;
  logic          above;
  logic          middle;
  logic          out_valid;
  logic          out_pixel;
  logic          out_row_end;
  logic          out_frame_end;

  assign accept       = in_if.valid && in_if.ready;
  assign in_if.ready  = !hold;

  bmc_scan_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .operation (in_if.operation),
    .pixel_in  (in_if.pixel_in),
    .item      (item),
    .col       (col),
    .mode      (mode),
    .restart   (restart)
  );

  bmc_line_mem #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (item.valid),
    .rd_addr (col),
    .wb_en   (wb_en),
    .wb_pix  (wb_pix),
    .above   (above),
    .middle  (middle)
  );

  bmc_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (item),
    .mode          (mode),
    .restart       (restart),
    .above         (above),
    .middle        (middle),
    .out_ready     (out_if.ready),
    .hold          (hold),
    .wb_en         (wb_en),
    .wb_pix        (wb_pix),
    .out_valid     (out_valid),
    .out_pixel     (out_pixel),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  assign out_if.valid     = out_valid;
  assign out_if.pixel_out = out_pixel;
  assign out_if.row_end   = out_row_end;
  assign out_if.frame_end = out_frame_end;

  // the last pixel of a frame always closes a row
  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.frame_end |-> out_if.row_end)
    else $error("frame_end without row_end");

  // input backpressure only comes from a stalled result
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input stalled without output stall");

  // stalled with a full window stage: result kept, input blocked while out stalls
  a_stall_persists: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready && !out_if.ready |=> out_if.valid && (!in_if.ready || out_if.ready))
    else $error("input released while output still stalled");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bmc_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int SETTLE_WAIT  = 12;
  localparam int STALL_LIMIT  = 2000;  // outlasts the longest receiver hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic pixel_out;
    logic row_end;
    logic frame_end;
  } morph_px_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmc_in_if  in_ch ();
  bmc_out_if out_ch ();

  binary_morphology_cross #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // filter state mirrored on the testbench side
  bmc_mode_t   filt_mode;
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  bit          row_above [MAX_W];
  bit          row_middle[MAX_W];
  bit [8:0]    win;
  int unsigned scan_col;
  int unsigned scan_row;
  int unsigned emit_count;

  morph_px_t   expected_px[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int          hold_left;
  int unsigned quiet_cycles;
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned frames_seen;
  int unsigned useful_items;

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_scan();
    win        = '0;
    scan_col   = 0;
    scan_row   = 0;
    emit_count = 0;
  endfunction

  // expected output for one accepted item, pushed in order
  task automatic predict_cross(input logic op, input logic pix_i);
    int unsigned w, h, col, k, p, r, c;
    bit a, m, pix, ctr, up, dn, lf, rt, res;
    morph_px_t px;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    if (op == OP_DRAIN && scan_row < h) return;
    useful_items++;
    pix = (scan_row >= h) ? 1'b0 : pix_i;
    col = (scan_col >= w) ? 0 : scan_col;
    a = row_above[col];
    m = row_middle[col];
    row_above[col]  = m;
    row_middle[col] = pix;
    // rows of three, oldest column in the low bit
    win = {pix, win[8], win[7], m, win[5], win[4], a, win[2], win[1]};
    k = scan_row * w + col;
    if (col + 1 >= w) begin
      scan_col = 0;
      scan_row++;
    end else begin
      scan_col = col + 1;
    end
    if (k < w + 1) return;
    p = emit_count;
    r = p / w;
    c = p % w;
    ctr = win[4];
    up  = win[1];
    dn  = win[7];
    lf  = win[3];
    rt  = win[5];
    if (r == 0 || c == 0 || r + 1 >= h || c + 1 >= w) begin
      res = ctr;
    end else if (filt_mode == MODE_ERODE) begin
      res = ctr & up & dn & lf & rt;
    end else begin
      res = ctr | up | dn | lf | rt;
    end
    px.pixel_out = res;
    px.row_end   = (c + 1 == w);
    px.frame_end = (p + 1 == h * w);
    expected_px.push_back(px);
    emit_count = p + 1;
    if (emit_count >= h * w) restart_scan();
  endtask

  task automatic send_item(input logic op, input logic pix);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.pixel_in  <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_cross(op, pix);
  endtask

  // stop offering, let every expected result out, then let the pipe go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic program_cfg(input bmc_mode_t md, input int unsigned w, input int unsigned h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_data  <= CFG_DATA_W'(md);
    @(posedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(posedge clk);
    cfg_we     <= 1'b0;
    filt_mode  = md;
    width_reg  = CFG_DATA_W'(w);
    height_reg = CFG_DATA_W'(h);
    restart_scan();
  endtask

  // one full frame plus its flush; noisy frames mix in ignored drains and late pixels
  task automatic run_frame(input int unsigned density, input bit noisy, input int pause_at);
    int unsigned w, h, i;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    for (i = 0; i < w * h; i++) begin
      if (pause_at >= 0 && i == pause_at) settle();
      if (noisy && $urandom_range(9) == 0) send_item(OP_DRAIN, 1'($urandom_range(1)));
      send_item(OP_PIXEL, $urandom_range(99) < density);
    end
    for (i = 0; i <= w; i++) begin
      if (noisy && $urandom_range(3) == 0) send_item(OP_PIXEL, 1'($urandom_range(1)));
      else send_item(OP_DRAIN, 1'($urandom_range(1)));
    end
  endtask

  function automatic int unsigned pick_density();
    case ($urandom_range(2))
      0:       return 10;
      1:       return 50;
      default: return 90;
    endcase
  endfunction

  task automatic test_reset_state();
    // default frame is 1024 wide, so nothing comes out of these
    send_item(OP_DRAIN, 1'b1);
    send_item(OP_PIXEL, 1'b1);
    send_item(OP_PIXEL, 1'b0);
    send_item(OP_PIXEL, 1'b1);
    send_item(OP_PIXEL, 1'b1);
    settle();
  endtask

  task automatic test_special_cases();
    program_cfg(MODE_ERODE, 3, 3);
    send_item(OP_DRAIN, 1'b1);          // drain before the frame is in
    repeat (9) send_item(OP_PIXEL, 1'b1);
    send_item(OP_PIXEL, 1'b0);          // late pixel counts as a drain
    repeat (3) send_item(OP_DRAIN, 1'b0);
    send_item(OP_DRAIN, 1'b1);          // next frame has not started
    settle();
    // zero sizes act as a single pixel
    program_cfg(MODE_DILATE, 0, 0);
    send_item(OP_PIXEL, 1'b1);
    send_item(OP_DRAIN, 1'b0);
    send_item(OP_DRAIN, 1'b1);
    settle();
  endtask

  task automatic test_size_extremes();
    // oversize width clamps to the maximum, so nothing is due this early
    program_cfg(MODE_DILATE, 2047, 3);
    repeat (12) send_item(OP_PIXEL, 1'($urandom_range(1)));
    settle();
    program_cfg(MODE_ERODE, 1, 1025);
    run_frame(50, 1'b0, -1);
    settle();
  endtask

  // abandon frames part way and restart them with a size write
  task automatic test_frame_restart();
    int unsigned w, h, n;
    repeat (4) begin
      w = $urandom_range(2, 8);
      h = $urandom_range(2, 8);
      program_cfg(bmc_mode_t'($urandom_range(1)), w, h);
      n = $urandom_range(1, w * h + w);
      repeat (n) send_item(OP_PIXEL, 1'($urandom_range(1)));
      settle();
    end
    program_cfg(MODE_ERODE, 5, 4);
    run_frame(90, 1'b0, -1);
    settle();
  endtask

  task automatic test_backpressure();
    program_cfg(MODE_DILATE, 8, 6);
    hold_left = HOLD_CYCLES;
    run_frame(50, 1'b0, 20);
    run_frame(10, 1'b0, 30);
    settle();
  endtask

  task automatic test_random_frames(input int unsigned n_items, input int unsigned src_pct,
                                    input int unsigned snk_pct);
    int unsigned start, w, h;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = useful_items;
    while (useful_items - start < n_items) begin
      if ($urandom_range(1) == 1) begin
        settle();
        w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
        h = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        program_cfg(bmc_mode_t'($urandom_range(1)), w, h);
      end
      run_frame(pick_density(), $urandom_range(3) == 0, -1);
    end
    settle();
  endtask

  // receiver side
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_out
    morph_px_t got, want;
    got = {out_ch.pixel_out, out_ch.row_end, out_ch.frame_end};
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (got.frame_end === 1'b1) frames_seen++;
      if (expected_px.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result: pix=%b row_end=%b frame_end=%b",
                   got.pixel_out, got.row_end, got.frame_end);
      end else begin
        want = expected_px.pop_front();
        if (got.pixel_out !== want.pixel_out || got.row_end !== want.row_end ||
            got.frame_end !== want.frame_end) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mismatch on result %0d: exp pix=%b row_end=%b frame_end=%b, got %b %b %b",
                     results_seen, want.pixel_out, want.row_end, want.frame_end,
                     got.pixel_out, got.row_end, got.frame_end);
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_PIXEL;
    in_ch.pixel_in  <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_MODE;
    cfg_data        <= '0;
    src_idle_pct    = 15;
    snk_idle_pct    = 68;
    hold_left       = 0;
    quiet_cycles    = 0;
    error_count     = 0;
    results_seen    = 0;
    frames_seen     = 0;
    useful_items    = 0;
    filt_mode       = MODE_ERODE;
    width_reg       = WIDTH_RESET;
    height_reg      = HEIGHT_RESET;
    for (int i = 0; i < MAX_W; i++) begin
      row_above[i]  = 1'b0;
      row_middle[i] = 1'b0;
    end
    restart_scan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_special_cases();
    test_frame_restart();
    test_backpressure();
    test_size_extremes();
    test_random_frames(210, 15, 68);
    test_random_frames(210, 68, 15);
    test_random_frames(220, 0, 0);

    error_count += expected_px.size();
    $display("covered %0d frames, %0d pixel and flush items, %0d results checked",
             frames_seen, useful_items, results_seen);
    $display("erosion and dilation, sizes 1x1 up to a clamped 1024-row frame, %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
